// ===== hdl/amep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amep_pkg
// Shared types and constants of the alpha mask edge profile block.
// ----------------------------------------------------------------------------
package amep_pkg;

   // Width of every position field in a result.
   localparam int RES_POS_W = 12;

   // Width of the size registers and of the threshold register.
   localparam int DIM_CFG_W = 13;
   localparam int ALPHA_W   = 8;

   // Configuration register indexes.
   localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
   localparam logic [1:0] REG_ALPHA_THRESHOLD = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_ROW    = 2'd0;
   localparam logic [1:0] KIND_COLUMN = 2'd1;
   localparam logic [1:0] KIND_BOX    = 2'd2;

   typedef struct packed {
      logic [1:0]           kind;
      logic [RES_POS_W-1:0] index;
      logic                 found;
      logic [RES_POS_W-1:0] first_pos;
      logic [RES_POS_W-1:0] last_pos;
      logic [RES_POS_W-1:0] box_low_y;
      logic [RES_POS_W-1:0] box_high_y;
      logic                 end_of_frame;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/amep_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amep_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module amep_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/alpha_mask_edge_profile.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alpha_mask_edge_profile
// Tracks opaque pixels of a raster alpha stream and reports row profiles,
// column profiles of the last row, and the frame bounding box.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                     Transaction
//  req_      in         valid/ready, alpha        one pixel, raster order
//  rsp_      out        valid/ready, 8 fields     one row/column/box result
//  csr_      in         valid/ready, index, data  one register write
//
//  A pixel is taken every cycle while no result waits; last-row pixels give one
//  result each, and the frame's last pixel gives three and holds req_ready low.
//  Column state lives in two RAMs read when a pixel is taken and written back
//  in the cycle after; a same-column read in that cycle is forwarded.
//  Reset clears positions and control; row 0 of each frame writes every column.
//  A stalled output fills a two-entry buffer, then stalls req_.
// ----------------------------------------------------------------------------
module alpha_mask_edge_profile
   import amep_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [ALPHA_W-1:0]   req_alpha,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [RES_POS_W-1:0]      rsp_index,
   output logic                      rsp_found,
   output logic [RES_POS_W-1:0]      rsp_first_pos,
   output logic [RES_POS_W-1:0]      rsp_last_pos,
   output logic [RES_POS_W-1:0]      rsp_box_low_y,
   output logic [RES_POS_W-1:0]      rsp_box_high_y,
   output logic                      rsp_end_of_frame,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [1:0]           csr_index,
   input  wire logic [DIM_CFG_W-1:0] csr_data
);

   localparam int POS_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CMP_W = ((DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W) + 1;
   localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);
   localparam int LOW_W = RES_POS_W + 1;

   function automatic logic [RES_POS_W-1:0] pos12(input logic [POS_W-1:0] v);
      logic [POS_W+RES_POS_W-1:0] ext;
      ext = {{RES_POS_W{1'b0}}, v};
      return ext[RES_POS_W-1:0];
   endfunction

   function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(v);
      if (ext == '0) begin
         return CMP_W'(1);
      end else if (ext > MAX_DIM_C) begin
         return MAX_DIM_C;
      end
      return ext;
   endfunction

   // ---------------------------------------------------------------- config
   logic [DIM_CFG_W-1:0] width_ff, height_ff;
   logic [ALPHA_W-1:0]   threshold_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DIM_CFG_W'(4096);
         height_ff    <= DIM_CFG_W'(4096);
         threshold_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_IMAGE_WIDTH:     width_ff     <= csr_data;
            REG_IMAGE_HEIGHT:    height_ff    <= csr_data;
            REG_ALPHA_THRESHOLD: threshold_ff <= csr_data[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- input stage
   logic             accept;
   logic [POS_W-1:0] col_pos_ff, col_pos_in;
   logic [POS_W-1:0] row_pos_ff, row_pos_in;
   logic             row_seen_ff, row_seen_in;
   logic [POS_W-1:0] row_first_ff, row_first_in, row_last_ff, row_last_in;
   logic             frame_seen_ff, frame_seen_in;
   logic [POS_W-1:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic [POS_W-1:0] min_y_ff, min_y_in, max_y_ff, max_y_in;

   logic             opaque, row_end, last_row;
   logic             upd_row_seen, upd_frame_seen;
   logic [POS_W-1:0] upd_row_first, upd_row_last;
   logic [POS_W-1:0] upd_min_x, upd_max_x, upd_min_y, upd_max_y;

   assign accept = req_valid && req_ready;
   assign opaque = req_alpha > threshold_ff;
   assign row_end  = (CMP_W'(col_pos_ff) + CMP_W'(1)) >= clamp_dim(width_ff);
   assign last_row = (CMP_W'(row_pos_ff) + CMP_W'(1)) >= clamp_dim(height_ff);

   always_comb begin
      upd_row_seen   = row_seen_ff;
      upd_row_first  = row_first_ff;
      upd_row_last   = row_last_ff;
      upd_frame_seen = frame_seen_ff;
      upd_min_x      = min_x_ff;
      upd_max_x      = max_x_ff;
      upd_min_y      = min_y_ff;
      upd_max_y      = max_y_ff;
      if (opaque) begin
         if (!row_seen_ff) begin
            upd_row_first = col_pos_ff;
         end
         upd_row_last = col_pos_ff;
         upd_row_seen = 1'b1;
         if (!frame_seen_ff) begin
            upd_min_x = col_pos_ff;
            upd_max_x = col_pos_ff;
            upd_min_y = row_pos_ff;
            upd_max_y = row_pos_ff;
         end else begin
            if (col_pos_ff < min_x_ff) upd_min_x = col_pos_ff;
            if (col_pos_ff > max_x_ff) upd_max_x = col_pos_ff;
            if (row_pos_ff < min_y_ff) upd_min_y = row_pos_ff;
            if (row_pos_ff > max_y_ff) upd_max_y = row_pos_ff;
         end
         upd_frame_seen = 1'b1;
      end

      col_pos_in    = col_pos_ff;
      row_pos_in    = row_pos_ff;
      row_seen_in   = row_seen_ff;
      row_first_in  = row_first_ff;
      row_last_in   = row_last_ff;
      frame_seen_in = frame_seen_ff;
      min_x_in      = min_x_ff;
      max_x_in      = max_x_ff;
      min_y_in      = min_y_ff;
      max_y_in      = max_y_ff;
      if (accept) begin
         row_seen_in   = upd_row_seen;
         row_first_in  = upd_row_first;
         row_last_in   = upd_row_last;
         frame_seen_in = upd_frame_seen;
         min_x_in      = upd_min_x;
         max_x_in      = upd_max_x;
         min_y_in      = upd_min_y;
         max_y_in      = upd_max_y;
         if (row_end) begin
            col_pos_in   = '0;
            row_seen_in  = 1'b0;
            row_first_in = '0;
            row_last_in  = '0;
            if (last_row) begin
               row_pos_in    = '0;
               frame_seen_in = 1'b0;
               min_x_in      = '0;
               max_x_in      = '0;
               min_y_in      = '0;
               max_y_in      = '0;
            end else begin
               row_pos_in = row_pos_ff + POS_W'(1);
            end
         end else begin
            col_pos_in = col_pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff    <= '0;
         row_pos_ff    <= '0;
         row_seen_ff   <= 1'b0;
         row_first_ff  <= '0;
         row_last_ff   <= '0;
         frame_seen_ff <= 1'b0;
         min_x_ff      <= '0;
         max_x_ff      <= '0;
         min_y_ff      <= '0;
         max_y_ff      <= '0;
      end else begin
         col_pos_ff    <= col_pos_in;
         row_pos_ff    <= row_pos_in;
         row_seen_ff   <= row_seen_in;
         row_first_ff  <= row_first_in;
         row_last_ff   <= row_last_in;
         frame_seen_ff <= frame_seen_in;
         min_x_ff      <= min_x_in;
         max_x_ff      <= max_x_in;
         min_y_ff      <= min_y_in;
         max_y_ff      <= max_y_in;
      end
   end

   // --------------------------------------------------------- column stores
   logic [LOW_W-1:0]     low_rd, low_wr;
   logic [RES_POS_W-1:0] high_rd, high_wr;
   logic                 s1_first_ff;
   logic [POS_W-1:0]     s1_x_ff;

   amep_ram #(.WIDTH(LOW_W), .DEPTH(MAX_DIM)) u_low_ram (
      .clock   (clock),
      .wr_en   (s1_first_ff),
      .wr_addr (s1_x_ff),
      .wr_data (low_wr),
      .rd_en   (accept),
      .rd_addr (col_pos_ff),
      .rd_data (low_rd)
   );

   amep_ram #(.WIDTH(RES_POS_W), .DEPTH(MAX_DIM)) u_high_ram (
      .clock   (clock),
      .wr_en   (s1_first_ff),
      .wr_addr (s1_x_ff),
      .wr_data (high_wr),
      .rd_en   (accept),
      .rd_addr (col_pos_ff),
      .rd_data (high_rd)
   );

   // ------------------------------------------------------ result stage s1
   logic [2:0]           s1_mask_ff;
   logic [RES_POS_W-1:0] s1_y_ff;
   logic                 s1_y_zero_ff, s1_opaque_ff;
   logic                 s1_row_found_ff, s1_frame_found_ff;
   logic [RES_POS_W-1:0] s1_row_first_ff, s1_row_last_ff;
   logic [RES_POS_W-1:0] s1_min_x_ff, s1_max_x_ff, s1_min_y_ff, s1_max_y_ff;
   logic                 byp_hit_ff;
   logic [LOW_W-1:0]     byp_low_ff;
   logic [RES_POS_W-1:0] byp_high_ff;

   logic [2:0]  sel;
   logic        push, pop, sel_last;
   result_type  push_data;
   logic [1:0]  cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_mask_ff  <= '0;
         s1_first_ff <= 1'b0;
      end else begin
         s1_first_ff <= accept;
         if (accept) begin
            s1_mask_ff <= {row_end && last_row, last_row, row_end};
         end else if (push) begin
            s1_mask_ff <= s1_mask_ff & ~sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff           <= col_pos_ff;
         s1_y_ff           <= pos12(row_pos_ff);
         s1_y_zero_ff      <= (row_pos_ff == '0);
         s1_opaque_ff      <= opaque;
         s1_row_found_ff   <= upd_row_seen;
         s1_row_first_ff   <= pos12(upd_row_first);
         s1_row_last_ff    <= pos12(upd_row_last);
         s1_frame_found_ff <= upd_frame_seen;
         s1_min_x_ff       <= pos12(upd_min_x);
         s1_max_x_ff       <= pos12(upd_max_x);
         s1_min_y_ff       <= pos12(upd_min_y);
         s1_max_y_ff       <= pos12(upd_max_y);
         // The RAM returns stale data when the entry is written back in the
         // same cycle as this read.
         byp_hit_ff        <= s1_first_ff && (s1_x_ff == col_pos_ff);
         byp_low_ff        <= low_wr;
         byp_high_ff       <= high_wr;
      end
   end

   logic [LOW_W-1:0]     old_low;
   logic [RES_POS_W-1:0] old_high;

   always_comb begin
      old_low  = byp_hit_ff ? byp_low_ff  : low_rd;
      old_high = byp_hit_ff ? byp_high_ff : high_rd;
      low_wr   = old_low;
      high_wr  = old_high;
      if (s1_y_zero_ff) begin
         low_wr  = {s1_opaque_ff, {RES_POS_W{1'b0}}};
         high_wr = '0;
      end else if (s1_opaque_ff) begin
         if (!old_low[RES_POS_W]) begin
            low_wr = {1'b1, s1_y_ff};
         end
         high_wr = s1_y_ff;
      end
   end

   // Pick the pending results in order: row, column, box.
   assign sel      = s1_mask_ff & (~s1_mask_ff + 3'd1);
   assign sel_last = (s1_mask_ff & ~sel) == '0;
   assign push     = (s1_mask_ff != '0) && (cnt_ff != 2'd2);
   assign req_ready = (s1_mask_ff == '0) || (push && sel_last);

   always_comb begin
      push_data = '0;
      if (sel[0]) begin
         push_data.kind      = KIND_ROW;
         push_data.index     = s1_y_ff;
         push_data.found     = s1_row_found_ff;
         push_data.first_pos = s1_row_found_ff ? s1_row_first_ff : '0;
         push_data.last_pos  = s1_row_found_ff ? s1_row_last_ff  : '0;
      end else if (sel[1]) begin
         push_data.kind      = KIND_COLUMN;
         push_data.index     = pos12(s1_x_ff);
         push_data.found     = low_wr[RES_POS_W];
         push_data.first_pos = low_wr[RES_POS_W] ? low_wr[RES_POS_W-1:0] : '0;
         push_data.last_pos  = low_wr[RES_POS_W] ? high_wr : '0;
      end else begin
         push_data.kind         = KIND_BOX;
         push_data.found        = s1_frame_found_ff;
         push_data.first_pos    = s1_frame_found_ff ? s1_min_x_ff : '0;
         push_data.last_pos     = s1_frame_found_ff ? s1_max_x_ff : '0;
         push_data.box_low_y    = s1_frame_found_ff ? s1_min_y_ff : '0;
         push_data.box_high_y   = s1_frame_found_ff ? s1_max_y_ff : '0;
         push_data.end_of_frame = 1'b1;
      end
   end

   // ------------------------------------------------ two-entry output buffer
   result_type head_ff, tail_ff;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if ((cnt_ff == 2'd0 && push) || (cnt_ff == 2'd1 && pop && push)) begin
         head_ff <= push_data;
      end else if (cnt_ff == 2'd2 && pop) begin
         head_ff <= tail_ff;
      end
      if (cnt_ff == 2'd1 && push && !pop) begin
         tail_ff <= push_data;
      end
   end

   assign rsp_kind         = head_ff.kind;
   assign rsp_index        = head_ff.index;
   assign rsp_found        = head_ff.found;
   assign rsp_first_pos    = head_ff.first_pos;
   assign rsp_last_pos     = head_ff.last_pos;
   assign rsp_box_low_y    = head_ff.box_low_y;
   assign rsp_box_high_y   = head_ff.box_high_y;
   assign rsp_end_of_frame = head_ff.end_of_frame;

endmodule
`default_nettype wire
